// File: hw/rtl/abvc_pkg.sv
// Shared types, widths and register indexes of the affine box view cull block.
`timescale 1ns / 1ps

package abvc_pkg;

	localparam int QW    = 32;
	localparam int QF    = 16;
	localparam int PW    = 2 * QW;
	localparam int SW    = PW - QF;
	localparam int OW    = SW + 2;
	localparam int LO_W  = OW / 2;
	localparam int HI_W  = OW - LO_W;
	localparam int PLO_W = LO_W + 1 + QW;
	localparam int PHI_W = HI_W + QW;
	localparam int FW    = PHI_W + LO_W + 1;
	localparam int TW    = FW - QF;
	localparam int UW    = TW + 2;
	localparam int IDW   = 16;
	localparam int CFG_W = 64;
	localparam int IDX_W = 3;

	typedef logic signed [QW-1:0]    q_t;
	typedef logic signed [PW-1:0]    prod_t;
	typedef logic signed [SW-1:0]    scl_t;
	typedef logic signed [OW-1:0]    coord_t;
	typedef logic signed [PLO_W-1:0] pp_lo_t;
	typedef logic signed [PHI_W-1:0] pp_hi_t;
	typedef logic signed [FW-1:0]    full_t;
	typedef logic signed [TW-1:0]    term_t;
	typedef logic signed [UW-1:0]    sum_t;

	localparam logic [IDX_W-1:0] REG_CULL_ENABLE       = 3'd0;
	localparam logic [IDX_W-1:0] REG_MATRIX_AB         = 3'd1;
	localparam logic [IDX_W-1:0] REG_MATRIX_CD         = 3'd2;
	localparam logic [IDX_W-1:0] REG_MATRIX_EF         = 3'd3;
	localparam logic [IDX_W-1:0] REG_VIEW_LEFT_TOP     = 3'd4;
	localparam logic [IDX_W-1:0] REG_VIEW_RIGHT_BOTTOM = 3'd5;
	localparam logic [IDX_W-1:0] REG_SCROLL_XY         = 3'd6;

	localparam logic [CFG_W-1:0] MATRIX_AB_RST = 64'h0001_0000_0000_0000;
	localparam logic [CFG_W-1:0] MATRIX_CD_RST = 64'h0000_0000_0001_0000;

	function automatic q_t hi_q(input logic [CFG_W-1:0] v);
		return q_t'(v[CFG_W-1:QW]);
	endfunction

	function automatic q_t lo_q(input logic [CFG_W-1:0] v);
		return q_t'(v[QW-1:0]);
	endfunction

	// pick a, b, c or d for one partial of a mapped coordinate
	function automatic q_t coef(input logic [CFG_W-1:0] ab, input logic [CFG_W-1:0] cd,
			input logic is_y, input logic second);
		q_t r;
		if (!is_y) begin
			r = second ? hi_q(cd) : hi_q(ab);
		end else begin
			r = second ? lo_q(cd) : lo_q(ab);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/affine_box_view_cull.sv
// Top level of the affine box view cull pipeline.
// Usage: one object enters on the input channel (in_valid / in_stall) and one
// keep verdict with the object id leaves on the output channel
// (out_valid / out_stall). A transfer happens at a rising edge with valid high
// and stall low. An object passes through the register stages in order (scroll
// and pivot products, offset, corner add, split matrix partials, partial merge
// and floor, affine sums, overlap compare); throughput is one object per cycle
// while the output is not stalled.
// A stalled output holds its result; stages behind it keep filling into
// bubbles, so in_stall rises only when every stage holds an object.
// Configuration uses cfg_write / cfg_index / cfg_data, one register per write;
// the user must write only while no object is in flight; the block does not enforce it.
// Reset (arst_n low) empties the pipeline and returns the registers to
// culling on, identity matrix, zero translation, view and scroll.
`timescale 1ns / 1ps

module affine_box_view_cull (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [abvc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [abvc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [abvc_pkg::IDW-1:0]      object_id,
	input  logic                          has_cull_data,
	input  logic signed [abvc_pkg::QW-1:0] obj_x,
	input  logic signed [abvc_pkg::QW-1:0] obj_y,
	input  logic signed [abvc_pkg::QW-1:0] obj_w,
	input  logic signed [abvc_pkg::QW-1:0] obj_h,
	input  logic signed [abvc_pkg::QW-1:0] factor_x,
	input  logic signed [abvc_pkg::QW-1:0] factor_y,
	input  logic signed [abvc_pkg::QW-1:0] pivot_x,
	input  logic signed [abvc_pkg::QW-1:0] pivot_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [abvc_pkg::IDW-1:0]      result_id,
	output logic                          keep
);

	logic                         cull_enable_q;
	logic [abvc_pkg::CFG_W-1:0]   matrix_ab_q;
	logic [abvc_pkg::CFG_W-1:0]   matrix_cd_q;
	logic [abvc_pkg::CFG_W-1:0]   matrix_ef_q;
	logic [abvc_pkg::CFG_W-1:0]   view_left_top_q;
	logic [abvc_pkg::CFG_W-1:0]   view_right_bottom_q;
	logic [abvc_pkg::CFG_W-1:0]   scroll_xy_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	logic [abvc_pkg::IDW-1:0] id_s1, id_s2, id_s3, id_s4, id_s5, id_s6, id_s7;
	logic chk_s1, chk_s2, chk_s3, chk_s4, chk_s5, chk_s6;

	abvc_pkg::q_t    x_s1, y_s1, w_s1, h_s1;
	abvc_pkg::prod_t scx_s1, scy_s1, pvx_s1, pvy_s1, ad_s1, bc_s1;
	abvc_pkg::coord_t ox_s2, oy_s2;
	abvc_pkg::q_t    w_s2, h_s2;
	abvc_pkg::coord_t pt_s3 [4];
	abvc_pkg::pp_lo_t pplo_s4 [8];
	abvc_pkg::pp_hi_t pphi_s4 [8];
	abvc_pkg::term_t term_s5 [8];
	abvc_pkg::sum_t  sum_s6 [4];
	logic            keep_s7;

	abvc_pkg::scl_t  scx_f, scy_f, pvx_f, pvy_f;
	logic            overlap;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_enable_q       <= 1'b1;
			matrix_ab_q         <= abvc_pkg::MATRIX_AB_RST;
			matrix_cd_q         <= abvc_pkg::MATRIX_CD_RST;
			matrix_ef_q         <= '0;
			view_left_top_q     <= '0;
			view_right_bottom_q <= '0;
			scroll_xy_q         <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				abvc_pkg::REG_CULL_ENABLE:       cull_enable_q       <= cfg_data[0];
				abvc_pkg::REG_MATRIX_AB:         matrix_ab_q         <= cfg_data;
				abvc_pkg::REG_MATRIX_CD:         matrix_cd_q         <= cfg_data;
				abvc_pkg::REG_MATRIX_EF:         matrix_ef_q         <= cfg_data;
				abvc_pkg::REG_VIEW_LEFT_TOP:     view_left_top_q     <= cfg_data;
				abvc_pkg::REG_VIEW_RIGHT_BOTTOM: view_right_bottom_q <= cfg_data;
				abvc_pkg::REG_SCROLL_XY:         scroll_xy_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or its successor advances
	assign adv_s7 = !v_s7 || !out_stall;
	assign adv_s6 = !v_s6 || adv_s7;
	assign adv_s5 = !v_s5 || adv_s6;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
		end
	end

	// stage 1: scroll and pivot products, determinant products
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			id_s1  <= object_id;
			chk_s1 <= cull_enable_q && has_cull_data;
			x_s1   <= obj_x;
			y_s1   <= obj_y;
			w_s1   <= obj_w;
			h_s1   <= obj_h;
			scx_s1 <= abvc_pkg::hi_q(scroll_xy_q) * factor_x;
			scy_s1 <= abvc_pkg::lo_q(scroll_xy_q) * factor_y;
			pvx_s1 <= obj_w * pivot_x;
			pvy_s1 <= obj_h * pivot_y;
			ad_s1  <= abvc_pkg::hi_q(matrix_ab_q) * abvc_pkg::lo_q(matrix_cd_q);
			bc_s1  <= abvc_pkg::lo_q(matrix_ab_q) * abvc_pkg::hi_q(matrix_cd_q);
		end
	end

	// stage 2: floor the products and offset the top-left corner
	assign scx_f = scx_s1[abvc_pkg::PW-1:abvc_pkg::QF];
	assign scy_f = scy_s1[abvc_pkg::PW-1:abvc_pkg::QF];
	assign pvx_f = pvx_s1[abvc_pkg::PW-1:abvc_pkg::QF];
	assign pvy_f = pvy_s1[abvc_pkg::PW-1:abvc_pkg::QF];

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			id_s2  <= id_s1;
			chk_s2 <= chk_s1 && (ad_s1 != bc_s1);
			ox_s2  <= abvc_pkg::coord_t'(x_s1) - abvc_pkg::coord_t'(scx_f)
				- abvc_pkg::coord_t'(pvx_f);
			oy_s2  <= abvc_pkg::coord_t'(y_s1) - abvc_pkg::coord_t'(scy_f)
				- abvc_pkg::coord_t'(pvy_f);
			w_s2   <= w_s1;
			h_s2   <= h_s1;
		end
	end

	// stage 3: bottom-right corner
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			id_s3    <= id_s2;
			chk_s3   <= chk_s2;
			pt_s3[0] <= ox_s2;
			pt_s3[1] <= oy_s2;
			pt_s3[2] <= ox_s2 + abvc_pkg::coord_t'(w_s2);
			pt_s3[3] <= oy_s2 + abvc_pkg::coord_t'(h_s2);
		end
	end

	// stage 4 and 5: each of the eight matrix products split in two halves,
	// then merged and floored
	for (genvar k = 0; k < 8; k++) begin : g_term
		localparam int O  = k / 2;
		localparam int J  = k % 2;
		localparam int CI = ((O >= 2) ? 2 : 0) + J;
		localparam bit IS_Y   = (O % 2) == 1;
		localparam bit SECOND = J == 1;

		abvc_pkg::q_t  m;
		abvc_pkg::full_t merged;

		assign m = abvc_pkg::coef(matrix_ab_q, matrix_cd_q, IS_Y, SECOND);

		always_ff @(posedge clk) begin
			if (adv_s4) begin
				pplo_s4[k] <= $signed({1'b0, pt_s3[CI][abvc_pkg::LO_W-1:0]}) * m;
				pphi_s4[k] <= $signed(pt_s3[CI][abvc_pkg::OW-1:abvc_pkg::LO_W]) * m;
			end
		end

		assign merged = (abvc_pkg::full_t'(pphi_s4[k]) <<< abvc_pkg::LO_W)
			+ abvc_pkg::full_t'(pplo_s4[k]);

		always_ff @(posedge clk) begin
			if (adv_s5) begin
				term_s5[k] <= merged[abvc_pkg::FW-1:abvc_pkg::QF];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			id_s4  <= id_s3;
			chk_s4 <= chk_s3;
		end
		if (adv_s5) begin
			id_s5  <= id_s4;
			chk_s5 <= chk_s4;
		end
	end

	// stage 6: mapped corners tl.x, tl.y, br.x, br.y
	always_ff @(posedge clk) begin
		if (adv_s6) begin
			id_s6  <= id_s5;
			chk_s6 <= chk_s5;
			for (int o = 0; o < 4; o++) begin
				sum_s6[o] <= abvc_pkg::sum_t'(term_s5[2 * o]) + abvc_pkg::sum_t'(term_s5[2 * o + 1])
					+ abvc_pkg::sum_t'(((o % 2) == 0) ? abvc_pkg::hi_q(matrix_ef_q)
					: abvc_pkg::lo_q(matrix_ef_q));
			end
		end
	end

	// stage 7: strict overlap against the view rectangle
	assign overlap =
		(sum_s6[2] > abvc_pkg::sum_t'(abvc_pkg::hi_q(view_left_top_q))) &&
		(abvc_pkg::sum_t'(abvc_pkg::hi_q(view_right_bottom_q)) > sum_s6[0]) &&
		(sum_s6[3] > abvc_pkg::sum_t'(abvc_pkg::lo_q(view_left_top_q))) &&
		(abvc_pkg::sum_t'(abvc_pkg::lo_q(view_right_bottom_q)) > sum_s6[1]);

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			id_s7   <= id_s6;
			keep_s7 <= !chk_s6 || overlap;
		end
	end

	assign out_valid = v_s7;
	assign result_id = id_s7;
	assign keep      = keep_s7;

endmodule
